FILE: sv/infx_pkg.sv
// infx_pkg: word types, operator codes and character constants for the
// infix expression evaluator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package infx_pkg;

    // Pending operator codes
    localparam logic [1:0] OP_PLUS  = 2'd0;
    localparam logic [1:0] OP_MINUS = 2'd1;
    localparam logic [1:0] OP_TIMES = 2'd2;
    localparam logic [1:0] OP_DIV   = 2'd3;

    // ASCII codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TIMES = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int RESULT_W = 32;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic signed [RESULT_W-1:0] value;
        logic                       divide_by_zero;
    } t_out_word;

endpackage

`default_nettype wire

FILE: sv/infx_if.sv
// infx_if: valid/ready channel interfaces for the character input and the
// result output. Depends on infx_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface infx_in_if;
    import infx_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface infx_out_if;
    import infx_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/infix_expression_evaluator.sv
// infix_expression_evaluator: two-level precedence calculator fed one ASCII
// character per word. Depends on infx_pkg and the channel interfaces in infx_if.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Word                               | Accepted when
// i_in    | in  | char_code[7:0], last_char          | valid & ready
// o_out   | out | value[31:0] signed, divide_by_zero | valid & ready
//
// Sequencing: a digit or a space is taken in the idle state. An operator (or the
// last character) passes through the apply state, which applies + or -; for *
// the bit-serial shift-add multiplier, and for / with a nonzero divisor the
// restoring divider run one bit per cycle; / then ends in a sign-fix state.
// The last character ends in the emit state, which loads the result register.
// Reset: synchronous, active low; clears all state but the datapath registers.
// Stalls: the result sits in an output register; the block keeps taking
// characters while it waits and holds only when a second result is due.

module infix_expression_evaluator #(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    infx_in_if.sink    i_in,
    infx_out_if.source o_out
);
    import infx_pkg::*;

    localparam int W     = WORD_WIDTH;
    localparam int CNT_W = $clog2(W);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_APPLY = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DFIX  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    // Evaluator state
    logic [2:0]       r_state,    n_state;
    logic [W-1:0]     r_acc,      n_acc;      // number being typed
    logic [1:0]       r_op,       n_op;       // pending operator
    logic [W-1:0]     r_term,     n_term;
    logic [W-1:0]     r_sum,      n_sum;
    logic             r_div_err,  n_div_err;
    logic [1:0]       r_nextop,   n_nextop;   // operator carried by this char
    logic             r_last,     n_last;
    // Shared serial datapath: multiplicand/quotient, multiplier/divisor,
    // product/remainder
    logic [W-1:0]     r_opa,      n_opa;
    logic [W-1:0]     r_opb,      n_opb;
    logic [W-1:0]     r_part,     n_part;
    logic             r_neg,      n_neg;
    logic [CNT_W-1:0] r_cnt,      n_cnt;
    // Output register
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out_word,  n_out_word;

    logic             w_is_digit;
    logic             w_need_apply;
    logic [1:0]       w_char_op;
    logic [W-1:0]     w_digit;
    logic [W-1:0]     w_mul_step;
    logic [W:0]       w_div_shift;
    logic [W:0]       w_div_trial;
    logic [W-1:0]     w_total;
    logic [RESULT_W-1:0] w_total_fit;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    assign w_is_digit   = (i_in.data.char_code >= CH_ZERO) && (i_in.data.char_code <= CH_NINE);
    assign w_need_apply = (!w_is_digit && (i_in.data.char_code != CH_SPACE))
                          || i_in.data.last_char;
    assign w_digit      = W'(i_in.data.char_code[3:0]);

    always_comb begin
        case (i_in.data.char_code)
            CH_PLUS:  w_char_op = OP_PLUS;
            CH_MINUS: w_char_op = OP_MINUS;
            CH_TIMES: w_char_op = OP_TIMES;
            default:  w_char_op = OP_DIV;    // anything else divides
        endcase
    end

    assign w_mul_step  = r_part + (r_opb[0] ? r_opa : '0);
    assign w_div_shift = {r_part, r_opa[W-1]};
    assign w_div_trial = w_div_shift - {1'b0, r_opb};
    assign w_total     = r_sum + r_term;

    generate
        if (W >= RESULT_W) begin : g_trunc
            assign w_total_fit = w_total[RESULT_W-1:0];
        end else begin : g_sext
            assign w_total_fit = {{(RESULT_W-W){w_total[W-1]}}, w_total};
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_op        = r_op;
        n_term      = r_term;
        n_sum       = r_sum;
        n_div_err   = r_div_err;
        n_nextop    = r_nextop;
        n_last      = r_last;
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_part      = r_part;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_word  = r_out_word;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (w_is_digit) begin
                        // acc * 10 + digit
                        n_acc = (r_acc << 3) + (r_acc << 1) + w_digit;
                    end
                    n_nextop = w_char_op;
                    n_last   = i_in.data.last_char;
                    if (w_need_apply) begin
                        n_state = ST_APPLY;
                    end
                end
            end
            ST_APPLY: begin
                n_acc   = '0;
                n_op    = r_nextop;
                n_cnt   = CNT_W'(W - 1);
                n_part  = '0;
                n_state = r_last ? ST_EMIT : ST_IDLE;
                case (r_op)
                    OP_PLUS: begin
                        n_sum  = r_sum + r_term;
                        n_term = r_acc;
                    end
                    OP_MINUS: begin
                        n_sum  = r_sum + r_term;
                        n_term = '0 - r_acc;
                    end
                    OP_TIMES: begin
                        n_opa   = r_term;
                        n_opb   = r_acc;
                        n_state = ST_MUL;
                    end
                    default: begin
                        if (r_acc == '0) begin
                            n_div_err = 1'b1;
                            n_term    = '1;
                        end else begin
                            // work on magnitudes, fix the sign afterwards
                            n_opa   = r_term[W-1] ? ('0 - r_term) : r_term;
                            n_opb   = r_acc[W-1] ? ('0 - r_acc) : r_acc;
                            n_neg   = r_term[W-1] ^ r_acc[W-1];
                            n_state = ST_DIV;
                        end
                    end
                endcase
            end
            ST_MUL: begin
                n_part = w_mul_step;
                n_opa  = r_opa << 1;
                n_opb  = r_opb >> 1;
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_term  = w_mul_step;
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_DIV: begin
                if (!w_div_trial[W]) begin
                    n_part = w_div_trial[W-1:0];
                    n_opa  = {r_opa[W-2:0], 1'b1};
                end else begin
                    n_part = w_div_shift[W-1:0];
                    n_opa  = {r_opa[W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DFIX;
                end
            end
            ST_DFIX: begin
                n_term  = r_neg ? ('0 - r_opa) : r_opa;
                n_state = r_last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid                = 1'b1;
                    n_out_word.value           = w_total_fit;
                    n_out_word.divide_by_zero  = r_div_err;
                    n_acc     = '0;
                    n_op      = OP_PLUS;
                    n_term    = '0;
                    n_sum     = '0;
                    n_div_err = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_op        <= OP_PLUS;
            r_term      <= '0;
            r_sum       <= '0;
            r_div_err   <= 1'b0;
            r_nextop    <= OP_PLUS;
            r_last      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_op        <= n_op;
            r_term      <= n_term;
            r_sum       <= n_sum;
            r_div_err   <= n_div_err;
            r_nextop    <= n_nextop;
            r_last      <= n_last;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_opa      <= n_opa;
        r_opb      <= n_opb;
        r_part     <= n_part;
        r_neg      <= n_neg;
        r_out_word <= n_out_word;
    end

    // Serial loops count down one bit per cycle
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_MUL || r_state == ST_DIV) && r_cnt != '0)
            |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("serial counter skipped a step");

    // Applying an operator always clears the number being typed
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPLY) |=> (r_acc == '0))
        else $error("digit accumulator not cleared after apply");

    // Divide-by-zero flag only rises on a divide with a zero divisor
    a_dz_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_div_err) |-> $past(r_state == ST_APPLY && r_op == OP_DIV && r_acc == '0))
        else $error("divide-by-zero flag set without a zero divisor");

    // A new result word only comes from the emit state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_EMIT))
        else $error("result word raised outside emit");

endmodule

`default_nettype wire

FILE: verif/tb_infix_expression_evaluator.sv
// tb_infix_expression_evaluator: self-checking bench for the infix expression evaluator.
// Needs infx_pkg, the channel interfaces in infx_if and the evaluator RTL.
`timescale 1ns / 1ps

module tb_infix_expression_evaluator;
    import infx_pkg::*;

    // Characters not in the package
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HIGH  = 8'hFF;

    localparam int ITEM_TARGET   = 1750;
    localparam int QUIET_TAIL    = 250;   // last words sent with no idling
    localparam int HOLD_AT       = 600;   // long result hold starts here
    localparam int PAUSE_AT      = 1100;  // sender drains the block here
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 60;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int N_DIRECTED    = 33;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        typed;  // expected result written in the row
        logic [31:0] value;
        logic        dz;
    } t_stim_row;

    // Three short expressions: leading plus with a subtraction, most negative
    // over minus one (both numbers wrap), and a leading times followed by
    // two zero divisors, the odd characters 0xFF and NUL, ending on a space.
    t_stim_row directed_rows [0:N_DIRECTED-1] = '{
        '{CH_PLUS, 1'b0, 1'b0, 32'd0, 1'b0}, '{"9", 1'b0, 1'b0, 32'd0, 1'b0},
        '{CH_MINUS, 1'b0, 1'b0, 32'd0, 1'b0}, '{"4", 1'b1, 1'b1, 32'd5, 1'b0},
        '{"2", 1'b0, 1'b0, 32'd0, 1'b0}, '{"1", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"4", 1'b0, 1'b0, 32'd0, 1'b0}, '{"7", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"4", 1'b0, 1'b0, 32'd0, 1'b0}, '{"8", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"3", 1'b0, 1'b0, 32'd0, 1'b0}, '{"6", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"4", 1'b0, 1'b0, 32'd0, 1'b0}, '{"8", 1'b0, 1'b0, 32'd0, 1'b0},
        '{CH_SLASH, 1'b0, 1'b0, 32'd0, 1'b0},
        '{"4", 1'b0, 1'b0, 32'd0, 1'b0}, '{"2", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"9", 1'b0, 1'b0, 32'd0, 1'b0}, '{"4", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"9", 1'b0, 1'b0, 32'd0, 1'b0}, '{"6", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"7", 1'b0, 1'b0, 32'd0, 1'b0}, '{"2", 1'b0, 1'b0, 32'd0, 1'b0},
        '{"9", 1'b0, 1'b0, 32'd0, 1'b0}, '{"5", 1'b1, 1'b1, 32'h8000_0000, 1'b0},
        '{CH_TIMES, 1'b0, 1'b0, 32'd0, 1'b0}, '{"2", 1'b0, 1'b0, 32'd0, 1'b0},
        '{CH_MINUS, 1'b0, 1'b0, 32'd0, 1'b0}, '{"3", 1'b0, 1'b0, 32'd0, 1'b0},
        '{CH_HIGH, 1'b0, 1'b0, 32'd0, 1'b0}, '{"0", 1'b0, 1'b0, 32'd0, 1'b0},
        '{CH_NUL, 1'b0, 1'b0, 32'd0, 1'b0},
        '{CH_SPACE, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    infx_in_if  char_ch ();
    infx_out_if res_ch ();

    infix_expression_evaluator #(.WORD_WIDTH(32)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_ch),
        .o_out   (res_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Expected results, oldest first
    t_out_word expected_results[$];
    int        error_count = 0;
    int        items_sent  = 0;
    int        cycle_count = 0;

    // Shared idling controls
    bit stalls_on    = 1'b1;
    bit hold_results = 1'b0;
    int src_gap_pct  = 20;

    // Evaluator state mirrored by the predictor
    logic [31:0] num_acc;
    logic [1:0]  pend_op;
    logic [31:0] term_val;
    logic [31:0] sum_val;
    logic        dz_seen;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 100)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic clear_evaluator();
        num_acc  = '0;
        pend_op  = OP_PLUS;
        term_val = '0;
        sum_val  = '0;
        dz_seen  = 1'b0;
    endtask

    // Queue helpers: add at the tail
    task automatic append_char(ref logic [7:0] text[$], input logic [7:0] c);
        text.insert(text.size(), c);
    endtask

    task automatic expect_result(input t_out_word res);
        expected_results.insert(expected_results.size(), res);
    endtask

    // Signed divide truncating toward zero; zero divisor gives all ones,
    // and most negative over minus one wraps back to most negative.
    function automatic logic [31:0] quot_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        if (mb == '0)
            return '1;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    // One character through the predictor; done flags a result
    task automatic eval_char(input logic [7:0] c, input logic last,
                             output bit done, output t_out_word res);
        bit is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        done = 1'b0;
        res  = '0;
        if (is_digit)
            num_acc = num_acc * 32'd10 + 32'(c - CH_ZERO);
        if ((!is_digit && c != CH_SPACE) || last) begin
            case (pend_op)
                OP_PLUS: begin
                    sum_val  = sum_val + term_val;
                    term_val = num_acc;
                end
                OP_MINUS: begin
                    sum_val  = sum_val + term_val;
                    term_val = -num_acc;
                end
                OP_TIMES: begin
                    term_val = term_val * num_acc;
                end
                default: begin
                    if (num_acc == '0)
                        dz_seen = 1'b1;
                    term_val = quot_trunc(term_val, num_acc);
                end
            endcase
            // anything not + - * counts as divide
            if (c == CH_PLUS)
                pend_op = OP_PLUS;
            else if (c == CH_MINUS)
                pend_op = OP_MINUS;
            else if (c == CH_TIMES)
                pend_op = OP_TIMES;
            else
                pend_op = OP_DIV;
            num_acc = '0;
        end
        if (last) begin
            res.value          = sum_val + term_val;
            res.divide_by_zero = dz_seen;
            done               = 1'b1;
            clear_evaluator();
        end
    endtask

    // Offer one word, with an optional idle burst first; predicts once accepted
    task automatic send_char(input logic [7:0] c, input logic last,
                             output bit done, output t_out_word res);
        if (stalls_on && $urandom_range(0, 99) < src_gap_pct) begin
            char_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.data  <= '{char_code: c, last_char: last};
        do @(posedge i_clk); while (!char_ch.ready);
        items_sent++;
        eval_char(c, last, done, res);
    endtask

    task automatic add_spaces(ref logic [7:0] text[$]);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) append_char(text, CH_SPACE);
    endtask

    // Mostly short numbers; some long ones that wrap, and the extremes
    task automatic add_number(ref logic [7:0] text[$]);
        int    kind;
        int    i;
        string fixed;
        kind  = $urandom_range(0, 19);
        fixed = "";
        case (kind)
            0: fixed = "0";
            1: fixed = "2147483648";
            2: fixed = "4294967295";
            3: fixed = "2147483647";
            default: ;
        endcase
        if (fixed.len() > 0) begin
            for (i = 0; i < fixed.len(); i++)
                append_char(text, fixed[i]);
        end else begin
            repeat ((kind < 6) ? $urandom_range(4, 12) : $urandom_range(1, 3))
                append_char(text, CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    function automatic logic [7:0] pick_operator();
        int r;
        r = $urandom_range(0, 15);
        if (r < 4)
            return CH_PLUS;
        else if (r < 8)
            return CH_MINUS;
        else if (r < 12)
            return CH_TIMES;
        else if (r < 15)
            return CH_SLASH;
        return 8'($urandom_range(0, 255));
    endfunction

    // Well-formed expressions most of the time, else noise or jumbled tokens
    task automatic send_expression();
        logic [7:0] text[$];
        int         style;
        int         n_terms;
        int         i;
        bit         done;
        t_out_word  res;
        style = $urandom_range(0, 9);
        if (style == 0) begin
            repeat ($urandom_range(1, 8)) append_char(text, 8'($urandom_range(0, 255)));
        end else if (style == 1) begin
            repeat ($urandom_range(1, 8))
                case ($urandom_range(0, 2))
                    0: add_number(text);
                    1: append_char(text, pick_operator());
                    default: append_char(text, CH_SPACE);
                endcase
        end else begin
            if ($urandom_range(0, 9) == 0)
                append_char(text, pick_operator());
            n_terms = $urandom_range(1, 5);
            for (i = 0; i < n_terms; i++) begin
                if (i > 0) begin
                    add_spaces(text);
                    append_char(text, pick_operator());
                end
                add_spaces(text);
                add_number(text);
            end
            add_spaces(text);
        end
        for (i = 0; i < text.size(); i++) begin
            send_char(text[i], i == text.size() - 1, done, res);
            if (done)
                expect_result(res);
        end
    endtask

    // Stimulus: directed table, then random expressions
    initial begin : stimulus
        int        r;
        int        next_mode_at;
        bit        hold_done;
        bit        pause_done;
        bit        done;
        t_out_word res;
        i_rst_n       <= 1'b0;
        char_ch.valid <= 1'b0;
        char_ch.data  <= '0;
        clear_evaluator();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_DIRECTED; r++) begin
            send_char(directed_rows[r].ch, directed_rows[r].last, done, res);
            if (done) begin
                if (directed_rows[r].typed) begin
                    res.value          = directed_rows[r].value;
                    res.divide_by_zero = directed_rows[r].dz;
                end
                expect_result(res);
            end
        end

        next_mode_at = 0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= next_mode_at) begin
                // alternate busy, light and no-gap stretches
                case ($urandom_range(0, 2))
                    0: src_gap_pct = 0;
                    1: src_gap_pct = 15;
                    default: src_gap_pct = 50;
                endcase
                next_mode_at = items_sent + 40;
            end
            if (!hold_done && items_sent >= HOLD_AT) begin
                // receiver holds off; sender keeps going until the block backs up
                hold_results = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && items_sent >= PAUSE_AT) begin
                char_ch.valid <= 1'b0;
                wait (expected_results.size() == 0);
                @(posedge i_clk);
                pause_done = 1'b1;
            end
            if (items_sent >= ITEM_TARGET - QUIET_TAIL)
                stalls_on = 1'b0;
            send_expression();
        end

        char_ch.valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stall bursts, quiet stretches, one long hold
    initial begin : result_sink
        int stretch_left;
        int stall_pct;
        stretch_left = 0;
        stall_pct    = 0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(20, 100);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 40;
                endcase
            end
            stretch_left--;
            if (hold_results) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_results = 1'b0;
            end else if (stalls_on && $urandom_range(0, 99) < stall_pct) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%0d dz=%0b",
                                          res_ch.data.value, res_ch.data.divide_by_zero));
            end else begin
                want = expected_results.pop_front();
                if (res_ch.data.value !== want.value)
                    report_mismatch($sformatf("value got %0d want %0d",
                                              res_ch.data.value, want.value));
                if (res_ch.data.divide_by_zero !== want.divide_by_zero)
                    report_mismatch($sformatf("divide_by_zero got %0b want %0b",
                                              res_ch.data.divide_by_zero,
                                              want.divide_by_zero));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

FILE: files.f
sv/infx_pkg.sv
sv/infx_if.sv
sv/infix_expression_evaluator.sv
verif/tb_infix_expression_evaluator.sv
